>>> rtl/assert_macros.svh
// Assertion macros shared by the checker modules of the suction turbine block.
// Depends on nothing; included by rtl/stac_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define STAC_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// A condition that must hold in the cycle after its trigger.
`define STAC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/stac_pkg.sv
// Shared types, constants and helper functions of the suction turbine attach control.
// Depends on nothing; used by every module of the block.
package stac_pkg;

    localparam int DIST_W    = 8;
    localparam int LEVEL_W   = 7;
    localparam int FORCE_W   = 22;
    localparam int PRESS_W   = 20;
    localparam int PDIV_W    = 18;
    localparam int AREA_W    = 16;
    localparam int PROD_W    = 36;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 2;
    localparam int THR_Q_W   = 23;

    localparam int TURBINE_MAX_DEF = 100;

    // Item kinds carried on the input tuser.
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DETACH = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPREAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUP_AREA   = 2'd3;

    // Pressure per drive step (22 with 8 fraction bits).
    localparam logic [PRESS_W-1:0] CLOSE_GAIN = 20'd5632;
    // Force is the pressure-area product divided by this.
    localparam logic [PROD_W-1:0]  FORCE_DIV  = 36'd10000;
    // Product at which force exceeds 10.0 (force >= 2561 raw).
    localparam logic [PROD_W-1:0]  NORMAL_THR = 36'd25610000;
    localparam logic [FORCE_W-1:0] FORCE_MAX  = 22'h3FFFFF;
    localparam logic [LEVEL_W-1:0] ATTACH_LEVEL_MIN = 7'd10;

    // One input item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              close_aligned;
        logic [DIST_W-1:0] dist_c;
        logic [DIST_W-1:0] dist_b;
        logic [DIST_W-1:0] dist_a;
    } stac_item_t;

    // Configuration and the force thresholds derived from it.
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [DIST_W-1:0] near_limit;
        logic [DIST_W-1:0] max_spread;
        logic [PROD_W-1:0] thr_up;
        logic [PROD_W-1:0] thr_dn;
        logic              dn_ok;
        logic [PROD_W-1:0] thr_at;
    } stac_cfg_t;

    // Result of the state update, before the force division.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] target;
        logic [PROD_W-1:0]  prod;
        logic               attached;
    } stac_mid_t;

    // Floor division by five through a reciprocal; exact for x below 2**26.
    function automatic logic [24:0] div5(input logic [24:0] x);
        logic [50:0] prod;
        prod = 51'(x) * 51'd53687092;
        return 25'(prod >> 28);
    endfunction

endpackage

>>> rtl/stac_core.sv
// State update of the suction turbine attach control: pressure, force compares,
// target hysteresis and drive ramp, one item per cycle when fire is high. Depends on stac_pkg.
module stac_core #(
    parameter int TURBINE_MAX = stac_pkg::TURBINE_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  stac_pkg::stac_item_t item,
    input  stac_pkg::stac_cfg_t  cfg,
    output stac_pkg::stac_mid_t  mid_next
);

    localparam logic [stac_pkg::LEVEL_W-1:0] TMAX = stac_pkg::LEVEL_W'(TURBINE_MAX);
    localparam logic [stac_pkg::LEVEL_W-1:0] LEVEL_STEP = stac_pkg::LEVEL_W'(1);

    logic [stac_pkg::PDIV_W-1:0]  pdiv_reg, pdiv_next;
    logic [stac_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [stac_pkg::LEVEL_W-1:0] target_reg, target_next;
    logic [stac_pkg::LEVEL_W-1:0] drive_reg, drive_next;
    logic                         mode_reg, mode_next;

    logic [stac_pkg::PRESS_W-1:0] press_new;
    logic [stac_pkg::DIST_W-1:0]  hi_ab, lo_ab, dist_hi, dist_lo, spread;
    logic                         near_level, below_goal, above_goal, on_target;

    // Largest and smallest of the three distances.
    always_comb
    begin
        hi_ab   = (item.dist_a > item.dist_b) ? item.dist_a : item.dist_b;
        lo_ab   = (item.dist_a < item.dist_b) ? item.dist_a : item.dist_b;
        dist_hi = (hi_ab > item.dist_c) ? hi_ab : item.dist_c;
        dist_lo = (lo_ab < item.dist_c) ? lo_ab : item.dist_c;
        spread  = dist_hi - dist_lo;
        near_level = (dist_hi < cfg.near_limit) && (spread < cfg.max_spread);
    end

    // Next state for one item. The pressure register keeps p/5 so that a decay
    // step needs no divide in front of the area multiplier.
    always_comb
    begin
        pdiv_next   = pdiv_reg;
        prod_next   = prod_reg;
        target_next = target_reg;
        drive_next  = drive_reg;
        mode_next   = mode_reg;
        press_new   = '0;
        below_goal  = 1'b0;
        above_goal  = 1'b0;
        on_target   = (target_reg == drive_reg);

        case (item.kind)
            stac_pkg::KIND_TICK:
            begin
                press_new = item.close_aligned
                          ? stac_pkg::PRESS_W'(drive_reg) * stac_pkg::CLOSE_GAIN
                          : stac_pkg::PRESS_W'(pdiv_reg);
                pdiv_next = stac_pkg::PDIV_W'(stac_pkg::div5(25'(press_new)));
                prod_next = stac_pkg::PROD_W'(press_new) * stac_pkg::PROD_W'(cfg.area);

                below_goal = prod_next < cfg.thr_up;
                above_goal = cfg.dn_ok && (prod_next >= cfg.thr_dn);

                if (mode_reg)
                begin
                    if (near_level)
                    begin
                        if (below_goal && on_target && (target_reg < TMAX))
                            target_next = target_reg + LEVEL_STEP;
                        else if (above_goal && on_target && (target_reg != '0))
                            target_next = target_reg - LEVEL_STEP;
                    end
                    else if (target_reg != '0)
                    begin
                        target_next = target_reg - LEVEL_STEP;
                    end
                end

                if (target_next < drive_reg)
                    drive_next = drive_reg - LEVEL_STEP;
                else if (target_next > drive_reg)
                    drive_next = drive_reg + LEVEL_STEP;
            end
            stac_pkg::KIND_ATTACH:
            begin
                mode_next = 1'b1;
            end
            stac_pkg::KIND_DETACH:
            begin
                mode_next   = 1'b0;
                target_next = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Result fields from the updated state.
    always_comb
    begin
        mid_next.level  = drive_next;
        mid_next.target = target_next;
        mid_next.prod   = prod_next;
        if (mode_next)
            mid_next.attached = (prod_next >= cfg.thr_at)
                              && (drive_next > stac_pkg::ATTACH_LEVEL_MIN);
        else
            mid_next.attached = prod_next >= stac_pkg::NORMAL_THR;
    end

    // State registers, updated once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pdiv_reg   <= '0;
            prod_reg   <= '0;
            target_reg <= '0;
            drive_reg  <= '0;
            mode_reg   <= 1'b0;
        end
        else if (fire)
        begin
            pdiv_reg   <= pdiv_next;
            prod_reg   <= prod_next;
            target_reg <= target_next;
            drive_reg  <= drive_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

>>> rtl/stac_force.sv
// Output stage: divides the pressure-area product by 10000, saturates the force
// and holds the result item for the output handshake. Depends on stac_pkg.
module stac_force (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               mid_valid,
    input  stac_pkg::stac_mid_t                mid,
    input  logic                               ready,
    output logic                               out_free,
    output logic                               out_valid,
    output logic [stac_pkg::LEVEL_W-1:0]       out_level,
    output logic [stac_pkg::LEVEL_W-1:0]       out_target,
    output logic [stac_pkg::FORCE_W-1:0]       out_force,
    output logic                               out_attached
);

    // Division by 10000 as a shift by four, then a reciprocal of 625.
    localparam logic [64:0] RECIP_625  = 65'd7036874418;
    localparam int          RECIP_SHFT = 42;

    logic [31:0]                   scaled;
    logic [64:0]                   recip_prod;
    logic [22:0]                   quot;
    logic [stac_pkg::FORCE_W-1:0]  force_sat;

    logic                          valid_reg;
    logic [stac_pkg::LEVEL_W-1:0]  level_reg;
    logic [stac_pkg::LEVEL_W-1:0]  target_reg;
    logic [stac_pkg::FORCE_W-1:0]  force_reg;
    logic                          attached_reg;

    // Force from the product, saturated to the field range.
    always_comb
    begin
        scaled     = mid.prod[35:4];
        recip_prod = 65'(scaled) * RECIP_625;
        quot       = 23'(recip_prod >> RECIP_SHFT);
        force_sat  = (quot > 23'(stac_pkg::FORCE_MAX)) ? stac_pkg::FORCE_MAX
                                                       : quot[21:0];
    end

    assign out_free = !valid_reg || ready;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_free)
            valid_reg <= mid_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && mid_valid)
        begin
            level_reg    <= mid.level;
            target_reg   <= mid.target;
            force_reg    <= force_sat;
            attached_reg <= mid.attached;
        end
    end

    assign out_valid    = valid_reg;
    assign out_level    = level_reg;
    assign out_target   = target_reg;
    assign out_force    = force_reg;
    assign out_attached = attached_reg;

endmodule

>>> rtl/suction_turbine_attach_control.sv
// Suction turbine attach control, top level. Depends on stac_pkg, stac_core, stac_force.
// An item passes the input register, the mid register and the result register in order.
// Throughput: one item per cycle while m_tready is high, set by the state update
// through the pressure-area multiplier; input and result registers absorb output stalls.
// Reset (rst_n, asynchronous, active low) clears state and configuration to zero, but
// down threshold resets nonzero. Force thresholds are registered from goal registers.
module suction_turbine_attach_control #(
    parameter int TURBINE_MAX = stac_pkg::TURBINE_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dist_a [7:0], dist_b [15:8], dist_c [23:16], close_aligned [24], zero [31:25]
    input  logic [31:0]                       s_tdata,
    // kind [1:0]
    input  logic [stac_pkg::KIND_W-1:0]       s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // turbine_level [6:0], turbine_target [13:7], force_now [35:14],
    // attached [36], zero [39:37]
    output logic [39:0]                       m_tdata,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [stac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stac_pkg::CFG_W-1:0]        cfg_data
);

    logic                          in_valid_reg;
    stac_pkg::stac_item_t          item_reg;
    logic                          mid_valid_reg;
    stac_pkg::stac_mid_t           mid_reg;
    stac_pkg::stac_mid_t           mid_next;
    stac_pkg::stac_cfg_t           cfg;

    logic                          en_mid, en_in, out_free, fire;

    logic [stac_pkg::FORCE_W-1:0]  goal_reg;
    logic [stac_pkg::DIST_W-1:0]   near_reg;
    logic [stac_pkg::DIST_W-1:0]   spread_reg;
    logic [stac_pkg::AREA_W-1:0]   area_reg;
    logic [stac_pkg::THR_Q_W-1:0]  dn_q_reg;
    logic [stac_pkg::THR_Q_W-1:0]  at_q_reg;
    logic [stac_pkg::PROD_W-1:0]   thr_up_reg, thr_dn_reg, thr_at_reg;
    logic                          dn_ok_reg;

    logic [stac_pkg::LEVEL_W-1:0]  out_level, out_target;
    logic [stac_pkg::FORCE_W-1:0]  out_force;
    logic                          out_attached;

    // Pipeline flow: each stage moves when the one after it has room.
    assign en_mid   = !mid_valid_reg || out_free;
    assign en_in    = !in_valid_reg || en_mid;
    assign s_tready = en_in;
    assign fire     = en_mid && in_valid_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en_in)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en_in && s_tvalid)
        begin
            item_reg.kind          <= s_tuser;
            item_reg.dist_a        <= s_tdata[7:0];
            item_reg.dist_b        <= s_tdata[15:8];
            item_reg.dist_c        <= s_tdata[23:16];
            item_reg.close_aligned <= s_tdata[24];
        end
    end

    // Configuration registers; the goal write also stores the scaled goals
    // ceil(4*goal/5) and floor(6*goal/5)+1 used by the hysteresis compares.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg   <= '0;
            near_reg   <= '0;
            spread_reg <= '0;
            area_reg   <= '0;
            dn_q_reg   <= stac_pkg::THR_Q_W'(1);
            at_q_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stac_pkg::CFG_GOAL:
                begin
                    goal_reg <= cfg_data;
                    dn_q_reg <= stac_pkg::THR_Q_W'(
                                    stac_pkg::div5(25'(cfg_data) * 25'd6))
                              + stac_pkg::THR_Q_W'(1);
                    at_q_reg <= stac_pkg::THR_Q_W'(
                                    stac_pkg::div5(25'(cfg_data) * 25'd4 + 25'd4));
                end
                stac_pkg::CFG_NEAR_LIMIT: near_reg   <= cfg_data[7:0];
                stac_pkg::CFG_MAX_SPREAD: spread_reg <= cfg_data[7:0];
                stac_pkg::CFG_CUP_AREA:   area_reg   <= cfg_data[15:0];
                default:                  near_reg   <= near_reg;
            endcase
        end
    end

    // Thresholds on the pressure-area product, so force is not needed in the loop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_up_reg <= '0;
            thr_dn_reg <= stac_pkg::FORCE_DIV;
            dn_ok_reg  <= 1'b1;
            thr_at_reg <= '0;
        end
        else
        begin
            thr_up_reg <= stac_pkg::PROD_W'(goal_reg) * stac_pkg::FORCE_DIV;
            thr_dn_reg <= stac_pkg::PROD_W'(dn_q_reg) * stac_pkg::FORCE_DIV;
            dn_ok_reg  <= dn_q_reg <= stac_pkg::THR_Q_W'(stac_pkg::FORCE_MAX);
            thr_at_reg <= stac_pkg::PROD_W'(at_q_reg) * stac_pkg::FORCE_DIV;
        end
    end

    always_comb
    begin
        cfg.area       = area_reg;
        cfg.near_limit = near_reg;
        cfg.max_spread = spread_reg;
        cfg.thr_up     = thr_up_reg;
        cfg.thr_dn     = thr_dn_reg;
        cfg.dn_ok      = dn_ok_reg;
        cfg.thr_at     = thr_at_reg;
    end

    stac_core #(
        .TURBINE_MAX (TURBINE_MAX)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .cfg      (cfg),
        .mid_next (mid_next)
    );

    // Register between the state update and the force division.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (en_mid)
            mid_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            mid_reg <= mid_next;
    end

    stac_force u_force (
        .clk          (clk),
        .rst_n        (rst_n),
        .mid_valid    (mid_valid_reg),
        .mid          (mid_reg),
        .ready        (m_tready),
        .out_free     (out_free),
        .out_valid    (m_tvalid),
        .out_level    (out_level),
        .out_target   (out_target),
        .out_force    (out_force),
        .out_attached (out_attached)
    );

    assign m_tdata = {3'b000, out_attached, out_force, out_target, out_level};

endmodule

>>> rtl/stac_checker.sv
// Port-level checks of the suction turbine attach control, bound to the top level.
// Depends on stac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stac_checker #(
    parameter int TURBINE_MAX = stac_pkg::TURBINE_MAX_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    localparam logic [6:0]  TMAX       = 7'(TURBINE_MAX);
    localparam logic [21:0] FORCE_TEN  = 22'd2560;
    localparam logic [6:0]  LEVEL_TEN  = 7'd10;

    // A stalled result item holds its value.
    `STAC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Level and target never pass the turbine maximum.
    `STAC_ASSERT_SAME(a_level_max, clk, rst_n, m_tvalid, (m_tdata[6:0] <= TMAX) && (m_tdata[13:7] <= TMAX))

    // Attached needs either real force or a running turbine.
    `STAC_ASSERT_SAME(a_attached, clk, rst_n, m_tvalid && m_tdata[36], (m_tdata[35:14] > FORCE_TEN) || (m_tdata[6:0] > LEVEL_TEN))

    // With the output draining, the pipeline always has room for an item.
    `STAC_ASSERT_SAME(a_ready_flow, clk, rst_n, m_tready, s_tready)

endmodule

bind suction_turbine_attach_control stac_checker #(
    .TURBINE_MAX (TURBINE_MAX)
) u_stac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/testbench.sv
// Self-checking testbench for the suction turbine attach control block.
// Depends on stac_pkg and suction_turbine_attach_control; an internal cup model predicts
// every result item, which is compared field by field with the block's output stream.
module testbench;
    import stac_pkg::*;

    localparam int TURBINE_TOP = TURBINE_MAX_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 122;
    // Kind code that the block does not use; such items only report the state.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    // Normal-mode attach threshold: force above 10.0 with 8 fraction bits.
    localparam logic [FORCE_W-1:0] NORMAL_HOLD = 22'd2560;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] target;
        logic [FORCE_W-1:0] hold_force;
        logic               attached;
    } cup_result_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Cup model state and its copy of the configuration.
    logic [PRESS_W-1:0]   cup_pressure = '0;
    logic [FORCE_W-1:0]   cup_force = '0;
    logic [LEVEL_W-1:0]   tgt_level = '0;
    logic [LEVEL_W-1:0]   drv_level = '0;
    logic                 attach_on = 1'b0;
    logic [FORCE_W-1:0]   goal_cfg = '0;
    logic [DIST_W-1:0]    near_cfg = '0;
    logic [DIST_W-1:0]    spread_cfg = '0;
    logic [AREA_W-1:0]    area_cfg = '0;

    stac_item_t           items_to_send[$];
    cup_result_t          cup_results_due[$];
    stac_item_t           cur_item;
    cup_result_t          fresh_result;
    cup_result_t          want;
    logic                 in_taken = 1'b0;
    int                   in_idle_pct = 27;
    int                   out_idle_pct = 27;
    int                   idle_cycles = 0;
    int                   mismatch_count = 0;

    suction_turbine_attach_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint unsigned want_v,
                                   input longint unsigned got_v);
        $display("MISMATCH %s: expected %0d, got %0d", what, want_v, got_v);
        mismatch_count++;
    endtask

    // Applies one item to the cup model and returns the state reported after it.
    task automatic advance_cup(input stac_item_t it, output cup_result_t res);
        logic [31:0] boosted;
        logic [63:0] quotient;
        logic [7:0]  hi;
        logic [7:0]  lo;
        if (it.kind == KIND_TICK)
        begin
            // Pressure follows the drive when sealed, otherwise it leaks away.
            if (it.close_aligned)
            begin
                boosted = 32'(drv_level) * 32'd22 * 32'd256;
                cup_pressure = (boosted > 32'hFFFFF) ? 20'hFFFFF : boosted[19:0];
            end
            else
                cup_pressure = cup_pressure / 20'd5;
            quotient = 64'(cup_pressure) * 64'(area_cfg) / 64'd10000;
            cup_force = (quotient > 64'(FORCE_MAX)) ? FORCE_MAX : quotient[21:0];

            // Target steering with hysteresis while attaching.
            if (attach_on)
            begin
                hi = it.dist_a;
                lo = it.dist_a;
                if (it.dist_b > hi) hi = it.dist_b;
                if (it.dist_c > hi) hi = it.dist_c;
                if (it.dist_b < lo) lo = it.dist_b;
                if (it.dist_c < lo) lo = it.dist_c;
                if (hi < near_cfg && (hi - lo) < spread_cfg)
                begin
                    if (cup_force < goal_cfg && tgt_level == drv_level &&
                        tgt_level < TURBINE_TOP)
                        tgt_level++;
                    if (64'(cup_force) * 5 > 64'(goal_cfg) * 6 &&
                        tgt_level == drv_level && tgt_level > 0)
                        tgt_level--;
                end
                else if (tgt_level > 0)
                    tgt_level--;
            end

            // The drive ramps one step toward the target.
            if (tgt_level < drv_level)
                drv_level--;
            else if (tgt_level > drv_level)
                drv_level++;
        end
        else if (it.kind == KIND_ATTACH)
            attach_on = 1'b1;
        else if (it.kind == KIND_DETACH)
        begin
            attach_on = 1'b0;
            tgt_level = '0;
        end

        res.level = drv_level;
        res.target = tgt_level;
        res.hold_force = cup_force;
        if (attach_on)
            res.attached = (64'(cup_force) * 5 >= 64'(goal_cfg) * 4) &&
                           (drv_level > ATTACH_LEVEL_MIN);
        else
            res.attached = cup_force > NORMAL_HOLD;
    endtask

    // Input driver: presents the next pending item once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (items_to_send.size() > 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    cur_item = items_to_send.pop_front();
                    s_tdata <= {7'd0, cur_item.close_aligned, cur_item.dist_c,
                                cur_item.dist_b, cur_item.dist_a};
                    s_tuser <= cur_item.kind;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Monitor: predicts on accepted inputs, checks accepted results, runs the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                advance_cup(cur_item, fresh_result);
                cup_results_due.push_back(fresh_result);
            end
            if (m_tvalid && m_tready)
            begin
                if (cup_results_due.size() == 0)
                    report_mismatch("result item with nothing pending", 0, 0);
                else
                begin
                    want = cup_results_due.pop_front();
                    if (m_tdata[6:0] !== want.level)
                        report_mismatch("turbine_level", want.level, m_tdata[6:0]);
                    if (m_tdata[13:7] !== want.target)
                        report_mismatch("turbine_target", want.target, m_tdata[13:7]);
                    if (m_tdata[35:14] !== want.hold_force)
                        report_mismatch("force_now", want.hold_force, m_tdata[35:14]);
                    if (m_tdata[36] !== want.attached)
                        report_mismatch("attached", want.attached, m_tdata[36]);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [KIND_W-1:0] kind, input int a, input int b,
                              input int c, input logic close);
        stac_item_t it;
        it.kind = kind;
        it.dist_a = a[7:0];
        it.dist_b = b[7:0];
        it.dist_c = c[7:0];
        it.close_aligned = close;
        items_to_send.push_back(it);
    endtask

    // A tick whose distances mostly describe a cup that is near and level.
    function automatic stac_item_t random_tick();
        stac_item_t it;
        int lo;
        int hi;
        int mid;
        int room;
        it.kind = KIND_TICK;
        it.close_aligned = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 85 && near_cfg > 0 && spread_cfg > 0)
        begin
            lo = $urandom_range(0, int'(near_cfg) - 1);
            room = int'(near_cfg) - 1 - lo;
            if (room > int'(spread_cfg) - 1)
                room = int'(spread_cfg) - 1;
            hi = lo + $urandom_range(0, room);
            mid = $urandom_range(lo, hi);
            case ($urandom_range(0, 2))
                0: {it.dist_a, it.dist_b, it.dist_c} = {lo[7:0], hi[7:0], mid[7:0]};
                1: {it.dist_a, it.dist_b, it.dist_c} = {hi[7:0], mid[7:0], lo[7:0]};
                default: {it.dist_a, it.dist_b, it.dist_c} = {mid[7:0], lo[7:0], hi[7:0]};
            endcase
        end
        else
        begin
            it.dist_a = 8'($urandom_range(0, 255));
            it.dist_b = 8'($urandom_range(0, 255));
            it.dist_c = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    // Mostly ticks, with occasional mode commands and spare kinds carrying noise.
    function automatic stac_item_t random_item();
        stac_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick >= 8)
            return random_tick();
        it.kind = (pick < 4) ? KIND_ATTACH : (pick < 6) ? KIND_DETACH : KIND_SPARE;
        it.dist_a = 8'($urandom_range(0, 255));
        it.dist_b = 8'($urandom_range(0, 255));
        it.dist_c = 8'($urandom_range(0, 255));
        it.close_aligned = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_GOAL:       goal_cfg = data;
            CFG_NEAR_LIMIT: near_cfg = data[7:0];
            CFG_MAX_SPREAD: spread_cfg = data[7:0];
            CFG_CUP_AREA:   area_cfg = data[15:0];
            default: ;
        endcase
    endtask

    // Rewrites all registers with the block idle, then lets the thresholds settle.
    task automatic set_registers(input int goal, input int near, input int spread,
                                 input int area);
        repeat (4) @(negedge clk);
        write_reg(CFG_GOAL, goal[21:0]);
        write_reg(CFG_NEAR_LIMIT, CFG_W'(near[7:0]));
        write_reg(CFG_MAX_SPREAD, CFG_W'(spread[7:0]));
        write_reg(CFG_CUP_AREA, CFG_W'(area[15:0]));
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (3) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || s_tvalid || cup_results_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int area;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items: both modes, spare kind, distance extremes and window edges.
        set_registers(200000, 128, 16, 10000);
        queue_item(KIND_TICK, 0, 0, 0, 1'b0);
        queue_item(KIND_TICK, 255, 255, 255, 1'b1);
        queue_item(KIND_SPARE, 255, 255, 255, 1'b1);
        queue_item(KIND_ATTACH, 0, 0, 0, 1'b0);
        repeat (6) queue_item(KIND_TICK, 10, 12, 11, 1'b1);
        queue_item(KIND_TICK, 10, 200, 10, 1'b1);
        queue_item(KIND_TICK, 5, 5, 5, 1'b0);
        queue_item(KIND_TICK, 127, 127, 112, 1'b1);
        queue_item(KIND_TICK, 128, 128, 128, 1'b1);
        queue_item(KIND_TICK, 100, 116, 100, 1'b1);
        queue_item(KIND_ATTACH, 255, 255, 255, 1'b1);
        queue_item(KIND_SPARE, 0, 0, 0, 1'b0);
        queue_item(KIND_DETACH, 7, 7, 7, 1'b1);
        queue_item(KIND_TICK, 0, 255, 0, 1'b1);
        queue_item(KIND_TICK, 255, 0, 255, 1'b0);
        queue_item(KIND_ATTACH, 0, 0, 0, 1'b0);
        queue_item(KIND_TICK, 255, 255, 255, 1'b0);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            in_idle_pct = (phase == 0) ? 0 : 27;
            out_idle_pct = (phase == 0) ? 0 : 27;
            case (phase)
                // Goal out of reach: on near ticks the target never falls, so it climbs toward the top.
                0: set_registers(4194303, 255, 255, 0);
                // Nothing counts as near: the target only falls.
                1: set_registers(0, 0, 0, 65535);
                // Anything goes.
                5: set_registers($urandom_range(0, 4194303), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 65535));
                // Goal reachable at some mid level, so the hysteresis comes into play.
                default:
                begin
                    area = $urandom_range(1000, 65535);
                    set_registers(int'((64'($urandom_range(5, 95)) * 5632 * area) / 10000),
                                  $urandom_range(1, 255), $urandom_range(1, 255), area);
                end
            endcase
            if (phase != 1)
                queue_item(KIND_ATTACH, 0, 0, 0, 1'b0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                items_to_send.push_back(random_item());
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
